/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

/* design/hrrnq_pkg.sv */
// ----------------------------------------------------------------------------
// hrrnq_pkg
// Shared widths, request and status codes, and the job entry layout.
// ----------------------------------------------------------------------------
package hrrnq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int RUN_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = 16;
    localparam int PROD_W = TIME_W + RUN_W;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO_RUN = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrive;
        logic [RUN_W-1:0]  run;
    } t_entry;

endpackage

/* design/hrrnq_mul.sv */
// ----------------------------------------------------------------------------
// hrrnq_mul
// Shared wait-by-run multiplier with a registered product.
// ----------------------------------------------------------------------------
module hrrnq_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hrrnq_pkg::TIME_W-1:0]  i_a,
    input  logic [hrrnq_pkg::RUN_W-1:0]   i_b,
    output logic [hrrnq_pkg::PROD_W-1:0]  o_prod
);

    localparam int PW = hrrnq_pkg::PROD_W;

    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_a) * PW'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

/* design/hrrn_ready_queue_top.sv */
// ----------------------------------------------------------------------------
// hrrn_ready_queue_top
// Highest-response-ratio-next ready table with one shared ratio multiplier.
// ----------------------------------------------------------------------------
// Push, and pop on an empty table: result strobe in the cycle after start, busy
// stays low. Pop of N held jobs: busy through LOAD, then SUB, M1, M2 and CMP
// for each job, as the single multiplier is used twice per compare, then SHR
// and SHW for each job above the removed one, which is read in SHR and written
// one slot down in SHW, and a final SHR; the result is strobed as busy falls.
// Synchronous active-low reset empties the table and clears the push count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrrn_ready_queue_top #(
    parameter int DEPTH = hrrnq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [hrrnq_pkg::TIME_W-1:0]  i_now,
    input  logic [hrrnq_pkg::ID_W-1:0]    i_job_id,
    input  logic [hrrnq_pkg::TIME_W-1:0]  i_arrive_time,
    input  logic [hrrnq_pkg::RUN_W-1:0]   i_run_time,
    output logic                          o_valid,
    output logic [hrrnq_pkg::STAT_W-1:0]  o_status,
    output logic [hrrnq_pkg::ID_W-1:0]    o_out_id,
    output logic [hrrnq_pkg::TIME_W-1:0]  o_out_arrive,
    output logic [hrrnq_pkg::RUN_W-1:0]   o_out_run,
    output logic [hrrnq_pkg::OCC_W-1:0]   o_occupancy,
    output logic [hrrnq_pkg::CNT_W-1:0]   o_pushes_total
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int XW  = AW + 1;
    localparam int OW  = hrrnq_pkg::OCC_W;
    localparam int TW  = hrrnq_pkg::TIME_W;
    localparam int RW  = hrrnq_pkg::RUN_W;
    localparam int PW  = hrrnq_pkg::PROD_W;
    localparam int NW  = hrrnq_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_M2   = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_SHR  = 3'd6;
    localparam logic [2:0] ST_SHW  = 3'd7;

    // control
    logic [2:0]    r_state;
    logic [CW-1:0] r_held;
    logic [NW-1:0] r_pushes;
    logic          r_o_valid;

    // scan datapath
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_bi;
    logic                  r_first;
    logic [TW-1:0]         r_now;
    logic [TW-1:0]         r_w;
    logic [TW-1:0]         r_bw;
    logic [RW-1:0]         r_br;
    logic [PW-1:0]         r_p1;
    hrrnq_pkg::t_entry     r_best;
    hrrnq_pkg::t_entry     r_rd;
    hrrnq_pkg::t_entry     r_mem [DEPTH];

    // result fields
    logic [hrrnq_pkg::STAT_W-1:0] r_o_status;
    logic [hrrnq_pkg::ID_W-1:0]   r_o_id;
    logic [TW-1:0]                r_o_arrive;
    logic [RW-1:0]                r_o_run;

    logic              accept;
    logic              is_push;
    logic              full;
    logic              push_ok;
    logic [XW-1:0]     idx_next_x;
    logic              last_entry;
    logic              shift_done;
    logic              take;
    logic [TW-1:0]     wait_cur;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    hrrnq_pkg::t_entry wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              mul_en;
    logic [TW-1:0]     mul_a;
    logic [RW-1:0]     mul_b;
    logic [PW-1:0]     prod;

    assign busy       = (r_state != ST_IDLE);
    assign accept     = start && !busy;
    assign is_push    = (i_req_type == hrrnq_pkg::REQ_PUSH);
    assign full       = (XW'(r_held) >= XW'(DEPTH));
    assign push_ok    = (i_run_time != '0) && !full;
    assign idx_next_x = XW'(r_idx) + XW'(1);
    assign last_entry = (idx_next_x == XW'(r_held));
    assign shift_done = (idx_next_x >= XW'(r_held));
    // wait_a * run_b > wait_b * run_a; the first entry seeds the best
    assign take       = r_first || (r_p1 > prod);
    // negative wait counts as zero
    assign wait_cur   = (r_now > r_rd.arrive) ? (r_now - r_rd.arrive) : '0;

    assign mul_en = (r_state == ST_M1) || (r_state == ST_M2);
    assign mul_a  = (r_state == ST_M1) ? r_w  : r_bw;
    assign mul_b  = (r_state == ST_M1) ? r_br : r_rd.run;

    hrrnq_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // slot memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_push && push_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_held);
                    wr_data = '{id: i_job_id, arrive: i_arrive_time, run: i_run_time};
                end
            end
            ST_LOAD: begin
                rd_en = 1'b1;
            end
            ST_CMP: begin
                if (!last_entry) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_next_x);
                end
            end
            ST_SHR: begin
                if (!shift_done) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(idx_next_x);
                end
            end
            ST_SHW: begin
                wr_en = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_held    <= '0;
            r_pushes  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (is_push) begin
                            r_o_valid <= 1'b1;
                            if (push_ok) begin
                                r_held   <= r_held + CW'(1);
                                r_pushes <= r_pushes + NW'(1);
                            end
                        end else if (r_held == '0) begin
                            r_o_valid <= 1'b1;
                        end else begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: r_state <= ST_SUB;
                ST_SUB:  r_state <= ST_M1;
                ST_M1:   r_state <= ST_M2;
                ST_M2:   r_state <= ST_CMP;
                ST_CMP: begin
                    r_state <= last_entry ? ST_SHR : ST_SUB;
                end
                ST_SHR: begin
                    if (shift_done) begin
                        r_held    <= r_held - CW'(1);
                        r_o_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_state <= ST_SHW;
                    end
                end
                ST_SHW:  r_state <= ST_SHR;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // scan and result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_now      <= i_now;
                    r_idx      <= '0;
                    r_first    <= 1'b1;
                    r_o_id     <= '0;
                    r_o_arrive <= '0;
                    r_o_run    <= '0;
                    if (is_push) begin
                        if (i_run_time == '0) begin
                            r_o_status <= hrrnq_pkg::STAT_ZERO_RUN;
                        end else if (full) begin
                            r_o_status <= hrrnq_pkg::STAT_FULL;
                        end else begin
                            r_o_status <= hrrnq_pkg::STAT_OK;
                        end
                    end else begin
                        r_o_status <= hrrnq_pkg::STAT_EMPTY;
                    end
                end
            end
            ST_SUB: begin
                r_w <= wait_cur;
            end
            ST_M2: begin
                r_p1 <= prod;
            end
            ST_CMP: begin
                r_first <= 1'b0;
                if (take) begin
                    r_bi   <= r_idx;
                    r_bw   <= r_w;
                    r_br   <= r_rd.run;
                    r_best <= r_rd;
                end
                // on the last job, start closing the gap at the winner
                if (last_entry) begin
                    r_idx <= take ? r_idx : r_bi;
                end else begin
                    r_idx <= AW'(idx_next_x);
                end
            end
            ST_SHR: begin
                if (shift_done) begin
                    r_o_status <= hrrnq_pkg::STAT_OK;
                    r_o_id     <= r_best.id;
                    r_o_arrive <= r_best.arrive;
                    r_o_run    <= r_best.run;
                end
            end
            ST_SHW: begin
                r_idx <= AW'(idx_next_x);
            end
            default: begin
                r_first <= r_first;
            end
        endcase
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_id       = r_o_id;
    assign o_out_arrive   = r_o_arrive;
    assign o_out_run      = r_o_run;
    assign o_occupancy    = OW'(r_held);
    assign o_pushes_total = r_pushes;

    `ASSERT_IMPLY(a_held_max, 1'b1, XW'(r_held) <= XW'(DEPTH))
    `ASSERT_NEXT(a_push_strobe, accept && is_push, o_valid && !busy)
    `ASSERT_IMPLY(a_scan_range, r_state == ST_CMP, XW'(r_idx) < XW'(r_held))
    `ASSERT_IMPLY(a_no_strobe_busy, busy, !o_valid || (r_state == ST_LOAD))

endmodule
